// ===== sv/pwfe_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package pwfe_pkg;

  // Fixed-point format of all fields
  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS  = 16;
  // Product width fed to the round/saturate helper
  localparam int PROD_W     = 68;

  // 2^64 / (2*pi), and the CORDIC start value (1/gain at 30 fraction bits)
  localparam logic [63:0] INV2PI      = 64'h28BE60DB9391054A;
  localparam logic [31:0] CORDIC_GAIN = 32'h26DD3B6A;

  // Register indexes on the configuration port
  localparam logic [2:0] CFG_E0_RE  = 3'd0;
  localparam logic [2:0] CFG_E0_IM  = 3'd1;
  localparam logic [2:0] CFG_WAVE_K = 3'd2;
  localparam logic [2:0] CFG_REFR_N = 3'd3;
  localparam logic [2:0] CFG_DIR_X  = 3'd4;
  localparam logic [2:0] CFG_DIR_Y  = 3'd5;

  // Quadrant codes (top two bits of the phase in turns)
  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;
  localparam logic [1:0] QUAD_3 = 2'd3;

  // One result beat
  typedef struct packed {
    logic [31:0] hz_re;
    logic [31:0] hz_im;
    logic [31:0] grad_x_re;
    logic [31:0] grad_x_im;
    logic [31:0] grad_y_re;
    logic [31:0] grad_y_im;
    logic [31:0] er_x_re;
    logic [31:0] er_x_im;
    logic [31:0] er_y_re;
    logic [31:0] er_y_im;
  } res_t;

  // CORDIC arctangent table, units of 2^-32 turn
  function automatic logic signed [31:0] atan_turn(input logic [4:0] i);
    logic signed [31:0] v;
    case (i)
      5'd0:  v = 32'sh20000000;
      5'd1:  v = 32'sh12E4051D;
      5'd2:  v = 32'sh09FB385B;
      5'd3:  v = 32'sh051111D4;
      5'd4:  v = 32'sh028B0D43;
      5'd5:  v = 32'sh0145D7E1;
      5'd6:  v = 32'sh00A2F61E;
      5'd7:  v = 32'sh00517C55;
      5'd8:  v = 32'sh0028BE53;
      5'd9:  v = 32'sh00145F2E;
      5'd10: v = 32'sh000A2F98;
      5'd11: v = 32'sh000517CC;
      5'd12: v = 32'sh00028BE6;
      5'd13: v = 32'sh000145F3;
      5'd14: v = 32'sh0000A2F9;
      5'd15: v = 32'sh0000517C;
      5'd16: v = 32'sh000028BE;
      5'd17: v = 32'sh0000145F;
      5'd18: v = 32'sh00000A2F;
      5'd19: v = 32'sh00000517;
      5'd20: v = 32'sh0000028B;
      5'd21: v = 32'sh00000145;
      5'd22: v = 32'sh000000A2;
      5'd23: v = 32'sh00000051;
      5'd24: v = 32'sh00000028;
      5'd25: v = 32'sh00000014;
      5'd26: v = 32'sh0000000A;
      5'd27: v = 32'sh00000005;
      5'd28: v = 32'sh00000002;
      5'd29: v = 32'sh00000001;
      default: v = 32'sh0;
    endcase
    return v;
  endfunction

  // Shift right by FRAC_BITS, round half away from zero, saturate
  function automatic logic [DATA_WIDTH-1:0] rnd_sat(input logic signed [PROD_W-1:0] p);
    logic             neg;
    logic [PROD_W-1:0] mag;
    logic [PROD_W-1:0] r;
    logic [PROD_W-1:0] lim;
    neg = p[PROD_W-1];
    mag = neg ? PROD_W'(-p) : PROD_W'(p);
    r   = (mag + (PROD_W'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
    lim = (PROD_W'(1) << (DATA_WIDTH - 1)) - (neg ? PROD_W'(0) : PROD_W'(1));
    if (r > lim) r = lim;
    return neg ? DATA_WIDTH'(PROD_W'(0) - r) : DATA_WIDTH'(r);
  endfunction

endpackage

`default_nettype wire

// ===== sv/plane_wave_field_evaluator.sv =====
// Throughput: one point per cycle while in_ready_o is high; one CORDIC iteration per pipeline stage.
// A stall on the result side holds the whole pipeline through a one-entry skid.
// After reset and after each configuration write, a sequencer on one
// shared multiplier forms k0*n/(2*pi), k0*n and the gradient factors; in_ready_o is low meanwhile.
`timescale 1ns / 1ps
`default_nettype none

module plane_wave_field_evaluator
  import pwfe_pkg::*;
#(
  parameter int CORDIC_STAGES = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [31:0] x_i,
  input  wire logic [31:0] y_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [31:0]      hz_re_o,
  output logic [31:0]      hz_im_o,
  output logic [31:0]      grad_x_re_o,
  output logic [31:0]      grad_x_im_o,
  output logic [31:0]      grad_y_re_o,
  output logic [31:0]      grad_y_im_o,
  output logic [31:0]      er_x_re_o,
  output logic [31:0]      er_x_im_o,
  output logic [31:0]      er_y_re_o,
  output logic [31:0]      er_y_im_o,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [31:0] cfg_data_i
);

  // Sequencer steps
  localparam logic [3:0] SQ_KN   = 4'd0;
  localparam logic [3:0] SQ_PP00 = 4'd1;
  localparam logic [3:0] SQ_PP01 = 4'd2;
  localparam logic [3:0] SQ_PP10 = 4'd3;
  localparam logic [3:0] SQ_PP11 = 4'd4;
  localparam logic [3:0] SQ_ACC  = 4'd5;
  localparam logic [3:0] SQ_GX   = 4'd6;
  localparam logic [3:0] SQ_GY   = 4'd7;
  localparam logic [3:0] SQ_GYW  = 4'd8;
  localparam logic [3:0] SQ_DONE = 4'd9;

  // ---------------------------------------------------------------
  // Configuration registers
  logic signed [31:0] e0_re_q, e0_im_q;
  logic [30:0]        wave_q, refr_q;
  logic signed [17:0] dx_q, dy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e0_re_q <= 32'sd65536;
      e0_im_q <= 32'sd0;
      wave_q  <= 31'd411775;
      refr_q  <= 31'd65536;
      dx_q    <= 18'sd65536;
      dy_q    <= 18'sd0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_E0_RE:  e0_re_q <= cfg_data_i;
        CFG_E0_IM:  e0_im_q <= cfg_data_i;
        CFG_WAVE_K: wave_q  <= cfg_data_i[30:0];
        CFG_REFR_N: refr_q  <= cfg_data_i[30:0];
        CFG_DIR_X:  dx_q    <= cfg_data_i[17:0];
        CFG_DIR_Y:  dy_q    <= cfg_data_i[17:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------
  // Derived-constant sequencer on one shared multiplier
  logic [3:0]          sq_q, sq_d;
  logic signed [32:0]  ma, mb;
  logic signed [65:0]  prod_q;
  logic [61:0]         p_q;
  logic [127:0]        acc_q;
  logic [127:0]        kt_sum;
  logic [63:0]         kt_q;
  logic signed [31:0]  kn_q, gx_q, gy_q;

  assign kt_sum = acc_q + (128'(1) << 63);

  always_comb begin
    ma   = 33'sd0;
    mb   = 33'sd0;
    sq_d = sq_q;
    unique case (sq_q)
      SQ_KN: begin
        ma = $signed({2'b0, wave_q});
        mb = $signed({2'b0, refr_q});
        sq_d = SQ_PP00;
      end
      SQ_PP00: begin
        ma = $signed({1'b0, prod_q[31:0]});
        mb = $signed({1'b0, INV2PI[31:0]});
        sq_d = SQ_PP01;
      end
      SQ_PP01: begin
        ma = $signed({1'b0, p_q[31:0]});
        mb = $signed({1'b0, INV2PI[63:32]});
        sq_d = SQ_PP10;
      end
      SQ_PP10: begin
        ma = $signed({3'b0, p_q[61:32]});
        mb = $signed({1'b0, INV2PI[31:0]});
        sq_d = SQ_PP11;
      end
      SQ_PP11: begin
        ma = $signed({3'b0, p_q[61:32]});
        mb = $signed({1'b0, INV2PI[63:32]});
        sq_d = SQ_ACC;
      end
      SQ_ACC: sq_d = SQ_GX;
      SQ_GX: begin
        ma = $signed({kn_q[31], kn_q});
        mb = $signed({{15{dx_q[17]}}, dx_q});
        sq_d = SQ_GY;
      end
      SQ_GY: begin
        ma = $signed({kn_q[31], kn_q});
        mb = $signed({{15{dy_q[17]}}, dy_q});
        sq_d = SQ_GYW;
      end
      SQ_GYW:  sq_d = SQ_DONE;
      SQ_DONE: sq_d = SQ_DONE;
      default: sq_d = SQ_DONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_q <= SQ_KN;
    end else if (cfg_we_i) begin
      sq_q <= SQ_KN;
    end else begin
      sq_q <= sq_d;
    end
  end

  // Sequencer datapath
  always_ff @(posedge clk_i) begin
    prod_q <= ma * mb;
    case (sq_q)
      SQ_PP00: p_q   <= prod_q[61:0];
      SQ_PP01: acc_q <= {64'b0, prod_q[63:0]};
      SQ_PP10: acc_q <= acc_q + (128'(prod_q[63:0]) << 32);
      SQ_PP11: acc_q <= acc_q + (128'(prod_q[63:0]) << 32);
      SQ_ACC: begin
        acc_q <= acc_q + (128'(prod_q[63:0]) << 64);
        kn_q  <= rnd_sat($signed({6'b0, p_q}));
      end
      SQ_GX:  kt_q <= kt_sum[127:64];
      SQ_GY:  gx_q <= rnd_sat(PROD_W'(prod_q));
      SQ_GYW: gy_q <= rnd_sat(PROD_W'(prod_q));
      default: ;
    endcase
  end

  // ---------------------------------------------------------------
  // Pipeline control: every stage moves while the skid is empty
  logic en;
  logic skid_v_q;
  logic in_acc;

  assign en         = !skid_v_q;
  assign in_ready_o = en && (sq_q == SQ_DONE);
  assign in_acc     = in_valid_i && in_ready_o;

  // Stage 1: projection onto the direction
  logic               v1_q;
  logic signed [50:0] s1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else if (en) v1_q <= in_acc;
  end

  always_ff @(posedge clk_i) begin
    if (en) s1_q <= 51'(dx_q * $signed(x_i)) + 51'(dy_q * $signed(y_i));
  end

  // Stage 2: partial products of the phase in turns (low 64 bits)
  logic        v2_q;
  logic [63:0] s64;
  logic [63:0] p00_q;
  logic [31:0] p01_q, p10_q;
  logic [63:0] p01_full, p10_full;

  assign s64      = 64'(s1_q);
  assign p01_full = kt_q[31:0] * s64[63:32];
  assign p10_full = kt_q[63:32] * s64[31:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else if (en) v2_q <= v1_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p00_q <= kt_q[31:0] * s64[31:0];
      p01_q <= p01_full[31:0];
      p10_q <= p10_full[31:0];
    end
  end

  // Stage 3: phase sum and rounding to 32 bits of turn
  logic        v3_q;
  logic [31:0] a3_q;
  logic [63:0] ph;
  logic [31:0] pmid;

  assign pmid = p01_q + p10_q;
  assign ph   = p00_q + {pmid, 32'b0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v3_q <= 1'b0;
    else if (en) v3_q <= v2_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) a3_q <= ph[63:32] + {31'b0, ph[31]};
  end

  // CORDIC: one rotation per stage
  logic               cv_q [CORDIC_STAGES];
  logic signed [31:0] cx_q [CORDIC_STAGES];
  logic signed [31:0] cy_q [CORDIC_STAGES];
  logic signed [31:0] cz_q [CORDIC_STAGES];
  logic [1:0]         cq_q [CORDIC_STAGES];

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
    logic               vi;
    logic signed [31:0] xi, yi, zi;
    logic [1:0]         qi;
    if (i == 0) begin : g_first
      assign vi = v3_q;
      assign xi = $signed(CORDIC_GAIN);
      assign yi = 32'sd0;
      assign zi = $signed({2'b0, a3_q[29:0]});
      assign qi = a3_q[31:30];
    end else begin : g_next
      assign vi = cv_q[i-1];
      assign xi = cx_q[i-1];
      assign yi = cy_q[i-1];
      assign zi = cz_q[i-1];
      assign qi = cq_q[i-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) cv_q[i] <= 1'b0;
      else if (en) cv_q[i] <= vi;
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        cq_q[i] <= qi;
        if (!zi[31]) begin
          cx_q[i] <= xi - (yi >>> i);
          cy_q[i] <= yi + (xi >>> i);
          cz_q[i] <= zi - atan_turn(5'(i));
        end else begin
          cx_q[i] <= xi + (yi >>> i);
          cy_q[i] <= yi - (xi >>> i);
          cz_q[i] <= zi + atan_turn(5'(i));
        end
      end
    end
  end

  // Quadrant stage: exact rotation by a multiple of 90 degrees
  logic               vq_q;
  logic signed [31:0] c_q, sn_q;
  logic signed [31:0] cl, sl;

  assign cl = cx_q[CORDIC_STAGES-1];
  assign sl = cy_q[CORDIC_STAGES-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vq_q <= 1'b0;
    else if (en) vq_q <= cv_q[CORDIC_STAGES-1];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      case (cq_q[CORDIC_STAGES-1])
        QUAD_1: begin c_q <= -sl; sn_q <= cl;  end
        QUAD_2: begin c_q <= -cl; sn_q <= -sl; end
        QUAD_3: begin c_q <= sl;  sn_q <= -cl; end
        default: begin c_q <= cl; sn_q <= sl;  end
      endcase
    end
  end

  // E1: amplitude times unit phasor, partial products
  logic               ve1_q;
  logic signed [63:0] m_rc_q, m_is_q, m_rs_q, m_ic_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ve1_q <= 1'b0;
    else if (en) ve1_q <= vq_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_rc_q <= e0_re_q * c_q;
      m_is_q <= e0_im_q * sn_q;
      m_rs_q <= e0_re_q * sn_q;
      m_ic_q <= e0_im_q * c_q;
    end
  end

  // E2: complex sum, rounded from 30 extra fraction bits
  logic               ve2_q;
  logic signed [34:0] ecr_q, eci_q;
  logic signed [64:0] dr, di;

  assign dr = 65'(m_rc_q) - 65'(m_is_q) + 65'sd536870912;
  assign di = 65'(m_rs_q) + 65'(m_ic_q) + 65'sd536870912;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ve2_q <= 1'b0;
    else if (en) ve2_q <= ve1_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ecr_q <= dr[64:30];
      eci_q <= di[64:30];
    end
  end

  // H1: Hz and Er products
  logic               vh1_q;
  logic signed [PROD_W-1:0] hr_p_q, hm_p_q, exr_p_q, exi_p_q, eyr_p_q, eyi_p_q;
  logic signed [31:0] n_s;
  logic signed [18:0] ndy, pdx;

  assign n_s = $signed({1'b0, refr_q});
  assign ndy = -$signed({dy_q[17], dy_q});
  assign pdx = $signed({dx_q[17], dx_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vh1_q <= 1'b0;
    else if (en) vh1_q <= ve2_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      hr_p_q  <= PROD_W'(n_s * ecr_q);
      hm_p_q  <= PROD_W'(n_s * eci_q);
      exr_p_q <= PROD_W'(ndy * ecr_q);
      exi_p_q <= PROD_W'(ndy * eci_q);
      eyr_p_q <= PROD_W'(pdx * ecr_q);
      eyi_p_q <= PROD_W'(pdx * eci_q);
    end
  end

  // H2: round and saturate Hz and Er
  logic               vh2_q;
  logic signed [31:0] hr_q, hm_q;
  logic [31:0]        exr_q, exi_q, eyr_q, eyi_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vh2_q <= 1'b0;
    else if (en) vh2_q <= vh1_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      hr_q  <= rnd_sat(hr_p_q);
      hm_q  <= rnd_sat(hm_p_q);
      exr_q <= rnd_sat(exr_p_q);
      exi_q <= rnd_sat(exi_p_q);
      eyr_q <= rnd_sat(eyr_p_q);
      eyi_q <= rnd_sat(eyi_p_q);
    end
  end

  // G1: gradient products i*k0*n*d*Hz
  logic               vg_q;
  logic signed [PROD_W-1:0] gxr_p_q, gxi_p_q, gyr_p_q, gyi_p_q;
  logic signed [31:0] g_hr_q, g_hm_q;
  logic [31:0]        g_exr_q, g_exi_q, g_eyr_q, g_eyi_q;
  logic signed [32:0] gxn, gyn, gxp, gyp;

  assign gxp = $signed({gx_q[31], gx_q});
  assign gyp = $signed({gy_q[31], gy_q});
  assign gxn = -gxp;
  assign gyn = -gyp;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vg_q <= 1'b0;
    else if (en) vg_q <= vh2_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      gxr_p_q <= PROD_W'(gxn * hm_q);
      gxi_p_q <= PROD_W'(gxp * hr_q);
      gyr_p_q <= PROD_W'(gyn * hm_q);
      gyi_p_q <= PROD_W'(gyp * hr_q);
      g_hr_q  <= hr_q;
      g_hm_q  <= hm_q;
      g_exr_q <= exr_q;
      g_exi_q <= exi_q;
      g_eyr_q <= eyr_q;
      g_eyi_q <= eyi_q;
    end
  end

  // Final rounding feeds the output register
  res_t res_d;

  always_comb begin
    res_d.hz_re     = g_hr_q;
    res_d.hz_im     = g_hm_q;
    res_d.grad_x_re = rnd_sat(gxr_p_q);
    res_d.grad_x_im = rnd_sat(gxi_p_q);
    res_d.grad_y_re = rnd_sat(gyr_p_q);
    res_d.grad_y_im = rnd_sat(gyi_p_q);
    res_d.er_x_re   = g_exr_q;
    res_d.er_x_im   = g_exi_q;
    res_d.er_y_re   = g_eyr_q;
    res_d.er_y_im   = g_eyi_q;
  end

  // ---------------------------------------------------------------
  // Output register with one-entry skid
  logic out_v_q;
  res_t out_q, skid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (skid_v_q) begin
      if (out_ready_i) skid_v_q <= 1'b0;
    end else if (vg_q) begin
      if (out_v_q && !out_ready_i) skid_v_q <= 1'b1;
      else out_v_q <= 1'b1;
    end else if (out_ready_i) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_v_q) begin
      if (out_ready_i) out_q <= skid_q;
    end else if (vg_q) begin
      if (out_v_q && !out_ready_i) skid_q <= res_d;
      else out_q <= res_d;
    end
  end

  assign out_valid_o = out_v_q;
  assign hz_re_o     = out_q.hz_re;
  assign hz_im_o     = out_q.hz_im;
  assign grad_x_re_o = out_q.grad_x_re;
  assign grad_x_im_o = out_q.grad_x_im;
  assign grad_y_re_o = out_q.grad_y_re;
  assign grad_y_im_o = out_q.grad_y_im;
  assign er_x_re_o   = out_q.er_x_re;
  assign er_x_im_o   = out_q.er_x_im;
  assign er_y_re_o   = out_q.er_y_re;
  assign er_y_im_o   = out_q.er_y_im;

endmodule

`default_nettype wire
